/* hw/rtl/gsce_pkg.sv */
// Shared constants for the gradient stop color evaluator.
package gsce_pkg;

  localparam int MAX_STOPS_DEF     = 6;
  localparam int POS_FRAC_BITS_DEF = 12;

  localparam int CHAN_W  = 8;
  localparam int CHANS   = 4;
  localparam int COLOR_W = CHAN_W * CHANS;
  localparam int CNT_W   = 3;

  localparam int REG_STOP_COUNT = 0;
  localparam int REG_STOP_BASE  = 1;

endpackage

/* hw/rtl/gradient_stop_color_eval_top.sv */
// Top level of the gradient stop color evaluator: stop registers, segment select and blend pipeline.
//
// Usage: software writes the stop count and up to MAX_STOPS stops (position and straight
// ARGB color) through the cfg_ port while no word is in flight. Each word on the in_
// channel carries one gradient position; each word on the out_ channel carries the
// interpolated straight color and its premultiplied form, in input order.
// A position is registered in the segment select stage, each divider stage, the blend
// multiply, straight color, premultiply product and output stages before out_valid.
// While out_ready is high, one word is accepted and one delivered every cycle, as set
// by the per-stage handshake; the divider forms the blend factor quotient two bits per stage.
// Reset clears the stop count and all stops, and empties the pipeline.
// When the receiver holds out_ready low, the output register keeps its word and the
// stages behind it keep filling; in_ready drops only once every stage holds a word,
// so nothing is lost or repeated.
module gradient_stop_color_eval_top #(
  parameter int MAX_STOPS     = gsce_pkg::MAX_STOPS_DEF,
  parameter int POS_FRAC_BITS = gsce_pkg::POS_FRAC_BITS_DEF,
  localparam int POS_W        = POS_FRAC_BITS + 1,
  localparam int CFG_W        = gsce_pkg::COLOR_W + POS_W,
  localparam int IDX_W        = $clog2(MAX_STOPS + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [IDX_W-1:0]            cfg_idx,
  input  logic [CFG_W-1:0]            cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [POS_W-1:0]            in_grad_pos,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [gsce_pkg::COLOR_W-1:0] out_straight_color,
  output logic [gsce_pkg::COLOR_W-1:0] out_premul_color
);

  localparam int CHAN_W  = gsce_pkg::CHAN_W;
  localparam int CHANS   = gsce_pkg::CHANS;
  localparam int COLOR_W = gsce_pkg::COLOR_W;
  localparam int CNT_W   = gsce_pkg::CNT_W;
  localparam int PROD_W  = CHAN_W + POS_W;
  localparam int PM_W    = 2 * CHAN_W;
  localparam int TAG_W   = 2 * COLOR_W;

  function automatic logic [CHAN_W-1:0] div255(input logic [PM_W-1:0] x);
    logic [PM_W:0] s;
    s = {1'b0, x} + {{(CHAN_W + 1){1'b0}}, x[PM_W-1:CHAN_W]} + {{PM_W{1'b0}}, 1'b1};
    return s[PM_W-1:CHAN_W];
  endfunction

  // Stop registers.
  logic [CNT_W-1:0]   stop_count_r;
  logic [POS_W-1:0]   stop_pos_r [MAX_STOPS];
  logic [COLOR_W-1:0] stop_col_r [MAX_STOPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_count_r <= '0;
      for (int k = 0; k < MAX_STOPS; k++) begin
        stop_pos_r[k] <= '0;
        stop_col_r[k] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_idx == IDX_W'(gsce_pkg::REG_STOP_COUNT)) begin
        stop_count_r <= cfg_data[CNT_W-1:0];
      end
      for (int k = 0; k < MAX_STOPS; k++) begin
        if (cfg_idx == IDX_W'(gsce_pkg::REG_STOP_BASE + k)) begin
          stop_col_r[k] <= cfg_data[COLOR_W-1:0];
          stop_pos_r[k] <= cfg_data[CFG_W-1:COLOR_W];
        end
      end
    end
  end

  // Segment select stage.
  logic               sel_v_r;
  logic [POS_W-1:0]   sel_d_r, sel_d_nxt;
  logic [POS_W-1:0]   sel_span_r, sel_span_nxt;
  logic [COLOR_W-1:0] sel_c0_r, sel_c0_nxt;
  logic [COLOR_W-1:0] sel_c1_r, sel_c1_nxt;
  logic               sel_rdy;
  logic               div_in_ready;

  always_comb begin
    logic [CNT_W-1:0]   n_eff;
    logic [POS_W-1:0]   pos_last;
    logic [COLOR_W-1:0] col_last;
    logic               found;
    n_eff    = (stop_count_r > CNT_W'(MAX_STOPS)) ? CNT_W'(MAX_STOPS) : stop_count_r;
    pos_last = stop_pos_r[0];
    col_last = stop_col_r[0];
    found    = 1'b0;
    for (int k = 0; k < MAX_STOPS; k++) begin
      if (n_eff == CNT_W'(k + 1)) begin
        pos_last = stop_pos_r[k];
        col_last = stop_col_r[k];
      end
    end
    sel_d_nxt    = '0;
    sel_span_nxt = POS_W'(1);
    sel_c0_nxt   = '0;
    sel_c1_nxt   = '0;
    if (n_eff == '0) begin
      sel_c0_nxt = '0;
      sel_c1_nxt = '0;
    end else if (n_eff == CNT_W'(1) || in_grad_pos <= stop_pos_r[0]) begin
      sel_c0_nxt = stop_col_r[0];
      sel_c1_nxt = stop_col_r[0];
    end else if (in_grad_pos >= pos_last) begin
      sel_c0_nxt = col_last;
      sel_c1_nxt = col_last;
    end else begin
      for (int i = 0; i < MAX_STOPS - 1; i++) begin
        if (!found && CNT_W'(i + 1) < n_eff && in_grad_pos <= stop_pos_r[i+1]) begin
          found        = 1'b1;
          sel_c0_nxt   = stop_col_r[i];
          sel_c1_nxt   = stop_col_r[i+1];
          sel_d_nxt    = in_grad_pos - stop_pos_r[i];
          sel_span_nxt = stop_pos_r[i+1] - stop_pos_r[i];
        end
      end
    end
  end

  assign sel_rdy  = !sel_v_r || div_in_ready;
  assign in_ready = sel_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_v_r <= 1'b0;
    end else if (sel_rdy) begin
      sel_v_r <= in_valid;
    end
    if (sel_rdy && in_valid) begin
      sel_d_r    <= sel_d_nxt;
      sel_span_r <= sel_span_nxt;
      sel_c0_r   <= sel_c0_nxt;
      sel_c1_r   <= sel_c1_nxt;
    end
  end

  // Blend factor divider.
  logic             div_v;
  logic [POS_W-1:0] div_quot;
  logic [TAG_W-1:0] div_tag;
  logic             mul_rdy;

  gsce_div #(
    .W     (POS_W),
    .TAG_W (TAG_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sel_v_r),
    .in_ready  (div_in_ready),
    .in_num    (sel_d_r),
    .in_den    (sel_span_r),
    .in_tag    ({sel_c0_r, sel_c1_r}),
    .out_valid (div_v),
    .out_ready (mul_rdy),
    .out_quot  (div_quot),
    .out_tag   (div_tag)
  );

  // Blend multiply stage.
  logic                          mul_v_r;
  logic [CHANS-1:0][PROD_W-1:0]  mul_prod_r, mul_prod_nxt;
  logic [CHANS-1:0]              mul_neg_r, mul_neg_nxt;
  logic [CHANS-1:0][CHAN_W-1:0]  mul_base_r, mul_base_nxt;
  logic                          str_rdy;

  always_comb begin
    logic [COLOR_W-1:0] c0;
    logic [COLOR_W-1:0] c1;
    logic [CHAN_W-1:0]  a;
    logic [CHAN_W-1:0]  b;
    logic [CHAN_W-1:0]  diff;
    c0 = div_tag[TAG_W-1:COLOR_W];
    c1 = div_tag[COLOR_W-1:0];
    for (int ch = 0; ch < CHANS; ch++) begin
      a = c0[ch*CHAN_W +: CHAN_W];
      b = c1[ch*CHAN_W +: CHAN_W];
      mul_neg_nxt[ch]  = (b < a);
      diff             = (b < a) ? (a - b) : (b - a);
      mul_prod_nxt[ch] = PROD_W'(diff) * PROD_W'(div_quot);
      mul_base_nxt[ch] = a;
    end
  end

  assign mul_rdy = !mul_v_r || str_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_v_r <= 1'b0;
    end else if (mul_rdy) begin
      mul_v_r <= div_v;
    end
    if (mul_rdy && div_v) begin
      mul_prod_r <= mul_prod_nxt;
      mul_neg_r  <= mul_neg_nxt;
      mul_base_r <= mul_base_nxt;
    end
  end

  // Straight color stage.
  logic               str_v_r;
  logic [COLOR_W-1:0] str_col_r, str_col_nxt;
  logic               pm_rdy;

  always_comb begin
    logic [CHAN_W-1:0] mag;
    for (int ch = 0; ch < CHANS; ch++) begin
      mag = mul_prod_r[ch][POS_FRAC_BITS +: CHAN_W];
      str_col_nxt[ch*CHAN_W +: CHAN_W] = mul_neg_r[ch] ? (mul_base_r[ch] - mag)
                                                       : (mul_base_r[ch] + mag);
    end
  end

  assign str_rdy = !str_v_r || pm_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      str_v_r <= 1'b0;
    end else if (str_rdy) begin
      str_v_r <= mul_v_r;
    end
    if (str_rdy && mul_v_r) begin
      str_col_r <= str_col_nxt;
    end
  end

  // Premultiply product stage.
  logic                          pm_v_r;
  logic [COLOR_W-1:0]            pm_col_r;
  logic [CHANS-2:0][PM_W-1:0]    pm_prod_r, pm_prod_nxt;
  logic                          out_rdy;

  always_comb begin
    logic [CHAN_W-1:0] al;
    al = str_col_r[COLOR_W-1 -: CHAN_W];
    for (int ch = 0; ch < CHANS - 1; ch++) begin
      pm_prod_nxt[ch] = PM_W'(str_col_r[ch*CHAN_W +: CHAN_W]) * PM_W'(al);
    end
  end

  assign pm_rdy = !pm_v_r || out_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pm_v_r <= 1'b0;
    end else if (pm_rdy) begin
      pm_v_r <= str_v_r;
    end
    if (pm_rdy && str_v_r) begin
      pm_col_r  <= str_col_r;
      pm_prod_r <= pm_prod_nxt;
    end
  end

  // Output register with divide by 255.
  logic               out_v_r;
  logic [COLOR_W-1:0] out_straight_r;
  logic [COLOR_W-1:0] out_premul_r, out_premul_nxt;

  always_comb begin
    out_premul_nxt[COLOR_W-1 -: CHAN_W] = pm_col_r[COLOR_W-1 -: CHAN_W];
    for (int ch = 0; ch < CHANS - 1; ch++) begin
      out_premul_nxt[ch*CHAN_W +: CHAN_W] = div255(pm_prod_r[ch]);
    end
  end

  assign out_rdy = !out_v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_rdy) begin
      out_v_r <= pm_v_r;
    end
    if (out_rdy && pm_v_r) begin
      out_straight_r <= pm_col_r;
      out_premul_r   <= out_premul_nxt;
    end
  end

  assign out_valid          = out_v_r;
  assign out_straight_color = out_straight_r;
  assign out_premul_color   = out_premul_r;

endmodule

/* hw/rtl/gsce_div.sv */
// Pipelined restoring divider, two quotient bits per stage, with a tag carried alongside.
module gsce_div #(
  parameter int W     = gsce_pkg::POS_FRAC_BITS_DEF + 1,
  parameter int TAG_W = 2 * gsce_pkg::COLOR_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [W-1:0]     in_num,
  input  logic [W-1:0]     in_den,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [W-1:0]     out_quot,
  output logic [TAG_W-1:0] out_tag
);

  localparam int NSTG = (W + 1) / 2;

  logic             v_r     [NSTG];
  logic [W:0]       rem_r   [NSTG];
  logic [W-1:0]     den_r   [NSTG];
  logic [W-1:0]     quot_r  [NSTG];
  logic [TAG_W-1:0] tag_r   [NSTG];

  logic             v_in    [NSTG];
  logic [W:0]       rem_in  [NSTG];
  logic [W-1:0]     den_in  [NSTG];
  logic [W-1:0]     quot_in [NSTG];
  logic [TAG_W-1:0] tag_in  [NSTG];

  logic [W:0]       rem_nxt [NSTG];
  logic [W-1:0]     quot_nxt[NSTG];

  logic             rdy     [NSTG+1];

  assign rdy[NSTG] = out_ready;
  assign in_ready  = rdy[0];

  genvar s;
  generate
    for (s = 0; s < NSTG; s++) begin : g_stg
      if (s == 0) begin : g_first
        assign v_in[s]    = in_valid;
        assign rem_in[s]  = {1'b0, in_num};
        assign den_in[s]  = in_den;
        assign quot_in[s] = '0;
        assign tag_in[s]  = in_tag;
      end else begin : g_next
        assign v_in[s]    = v_r[s-1];
        assign rem_in[s]  = rem_r[s-1];
        assign den_in[s]  = den_r[s-1];
        assign quot_in[s] = quot_r[s-1];
        assign tag_in[s]  = tag_r[s-1];
      end

      assign rdy[s] = !v_r[s] || rdy[s+1];

      always_comb begin
        logic [W:0]   r;
        logic [W-1:0] q;
        r = rem_in[s];
        q = quot_in[s];
        for (int j = 0; j < 2; j++) begin
          if (s * 2 + j < W) begin
            if (r >= {1'b0, den_in[s]}) begin
              r = r - {1'b0, den_in[s]};
              q = {q[W-2:0], 1'b1};
            end else begin
              q = {q[W-2:0], 1'b0};
            end
            r = {r[W-1:0], 1'b0};
          end
        end
        rem_nxt[s]  = r;
        quot_nxt[s] = q;
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[s] <= 1'b0;
        end else if (rdy[s]) begin
          v_r[s] <= v_in[s];
        end
        if (rdy[s] && v_in[s]) begin
          rem_r[s]  <= rem_nxt[s];
          den_r[s]  <= den_in[s];
          quot_r[s] <= quot_nxt[s];
          tag_r[s]  <= tag_in[s];
        end
      end
    end
  endgenerate

  assign out_valid = v_r[NSTG-1];
  assign out_quot  = quot_r[NSTG-1];
  assign out_tag   = tag_r[NSTG-1];

endmodule
